// ===== rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types and constants of the sd spi host sequencer
// phase codes, opcodes, command, status and card kind codes and the defaults of the parameters
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned InitIdleBytesDef = 20;

  localparam logic [1:0] OpByte  = 2'd0;
  localparam logic [1:0] OpInit  = 2'd1;
  localparam logic [1:0] OpRead1 = 2'd2;
  localparam logic [1:0] OpReadN = 2'd3;

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhClocks = 4'd1;
  localparam logic [3:0] PhCpre   = 4'd2;
  localparam logic [3:0] PhCbyte  = 4'd3;
  localparam logic [3:0] PhCskip  = 4'd4;
  localparam logic [3:0] PhCpoll  = 4'd5;
  localparam logic [3:0] PhEcho   = 4'd6;
  localparam logic [3:0] PhCsdtok = 4'd7;
  localparam logic [3:0] PhCsd    = 4'd8;
  localparam logic [3:0] PhDtok   = 4'd9;
  localparam logic [3:0] PhData   = 4'd10;
  localparam logic [3:0] PhDcrc   = 4'd11;

  localparam logic [5:0] Cmd0  = 6'd0;
  localparam logic [5:0] Cmd8  = 6'd8;
  localparam logic [5:0] Cmd9  = 6'd9;
  localparam logic [5:0] Cmd12 = 6'd12;
  localparam logic [5:0] Cmd17 = 6'd17;
  localparam logic [5:0] Cmd18 = 6'd18;
  localparam logic [5:0] Cmd41 = 6'd41;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StInitFail = 2'd1;
  localparam logic [1:0] StReject   = 2'd2;
  localparam logic [1:0] StBusy     = 2'd3;

  localparam logic [1:0] KindUnknown = 2'd0;
  localparam logic [1:0] KindStd     = 2'd1;
  localparam logic [1:0] KindHigh    = 2'd2;
  localparam logic [1:0] KindError   = 2'd3;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_active;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       block_end;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] r1_response;
    logic [1:0] card_kind;
    logic [32:0] capacity_blocks;
  } result_t;

endpackage

// ===== rtl/sdspi_core.sv =====
// ----------------------------------------------------------------------------
// sdspi_core: sequencer state and one step per request
// takes a request, updates the state and forms the registered result
// ----------------------------------------------------------------------------
module sdspi_core #(
  parameter int unsigned InitIdleBytes = sdspi_pkg::InitIdleBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [31:0]         block_addr_i,
  input  logic [7:0]          block_count_i,
  output sdspi_pkg::result_t  res_o
);
  import sdspi_pkg::*;

  logic [3:0]  phase_q, phase_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [31:0] arg_q, arg_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  kind_q, kind_d;
  logic [3:0]  bl_q, bl_d;
  logic [21:0] size_q, size_d;
  logic [2:0]  mult_q, mult_d;
  logic [32:0] cap_q, cap_d;
  logic [7:0]  resp_q, resp_d;
  logic        sel_q, sel_d;
  logic [1:0]  lst_q, lst_d;
  logic [5:0]  cmd_q, cmd_d;
  logic [7:0]  crc_q, crc_d;
  logic        pre_q, pre_d;

  logic       txv, dv, bend, done;
  logic [7:0] tx, dat;
  logic [9:0] cnt_inc;
  logic [3:0] len;
  logic [32:0] cap_std;
  logic [7:0] echo_exp;

  assign cnt_inc = cnt_q + 10'd1;

  function automatic logic [7:0] cmd_byte(input logic pre, input logic [5:0] cmd,
                                          input logic [31:0] arg, input logic [7:0] crc,
                                          input logic [2:0] k);
    logic [7:0] b;
    if (pre) begin
      b = (k == 3'd0) ? 8'h77 : ((k == 3'd5) ? 8'h01 : 8'h00);
    end else begin
      case (k)
        3'd0: b = {2'b01, cmd};
        3'd1: b = arg[31:24];
        3'd2: b = arg[23:16];
        3'd3: b = arg[15:8];
        3'd4: b = arg[7:0];
        default: b = crc;
      endcase
    end
    return b;
  endfunction

  always_comb begin
    len = (bl_q < 4'd9) ? 4'd9 : bl_q;
    cap_std = (({21'd0, size_q[11:0]} + 33'd1) << ({2'd0, mult_q} + 5'd2))
              << (len - 4'd9);
    case (cnt_q[1:0])
      2'd3:    echo_exp = 8'hAA;
      2'd2:    echo_exp = 8'h01;
      default: echo_exp = 8'h00;
    endcase
  end

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; arg_d = arg_q; left_d = left_q;
    kind_d = kind_q; bl_d = bl_q; size_d = size_q; mult_d = mult_q;
    cap_d = cap_q; resp_d = resp_q; sel_d = sel_q; lst_d = lst_q;
    cmd_d = cmd_q; crc_d = crc_q; pre_d = pre_q;
    txv = 1'b0; tx = 8'hFF; dv = 1'b0; dat = 8'h00; bend = 1'b0; done = 1'b0;

    if (phase_q == PhIdle) begin
      if (opcode_i == OpInit) begin
        sel_d = 1'b0; phase_d = PhClocks; cnt_d = '0; txv = 1'b1;
      end else if (opcode_i == OpRead1 || opcode_i == OpReadN) begin
        arg_d = (kind_q == KindStd) ? {block_addr_i[22:0], 9'd0} : block_addr_i;
        sel_d = 1'b1; left_d = block_count_i;
        cmd_d = (opcode_i == OpRead1) ? Cmd17 : Cmd18;
        crc_d = 8'h01; pre_d = 1'b0; phase_d = PhCpre; cnt_d = '0; txv = 1'b1;
      end
    end else if (opcode_i == OpByte) begin
      txv = 1'b1;
      case (phase_q)
        PhClocks: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= 10'(InitIdleBytes)) begin
            sel_d = 1'b1; cmd_d = Cmd0; arg_d = '0; crc_d = 8'h95; pre_d = 1'b0;
            phase_d = PhCpre; cnt_d = '0;
          end
        end
        PhCpre: begin
          phase_d = PhCbyte; cnt_d = '0;
          tx = cmd_byte(pre_q, cmd_q, arg_q, crc_q, 3'd0);
        end
        PhCbyte: begin
          cnt_d = cnt_inc;
          if (cnt_inc < 10'd6) tx = cmd_byte(pre_q, cmd_q, arg_q, crc_q, cnt_inc[2:0]);
          else phase_d = (!pre_q && cmd_q == Cmd12) ? PhCskip : PhCpoll;
        end
        PhCskip: phase_d = PhCpoll;
        PhCpoll: begin
          if (rx_byte_i != 8'hFF) begin
            resp_d = rx_byte_i;
            if (pre_q) begin
              pre_d = 1'b0; phase_d = PhCpre;
            end else begin
              // start a new command by default where one follows
              phase_d = PhCpre; cnt_d = '0;
              case (cmd_q)
                Cmd0: begin
                  cmd_d = Cmd8; arg_d = 32'h0000_01AA; crc_d = 8'h87; pre_d = 1'b0;
                end
                Cmd8: begin
                  if (rx_byte_i == 8'd5) begin
                    kind_d = KindStd; cmd_d = Cmd41; arg_d = 32'h4000_0000;
                    crc_d = 8'h01; pre_d = 1'b1;
                  end else if (rx_byte_i == 8'd1) begin
                    phase_d = PhEcho;
                  end else begin
                    kind_d = KindError; phase_d = PhIdle; done = 1'b1;
                    lst_d = StInitFail; txv = 1'b0;
                  end
                end
                Cmd41: begin
                  if (rx_byte_i == 8'd1) begin
                    arg_d = 32'h4000_0000; crc_d = 8'h01; pre_d = 1'b1;
                  end else begin
                    cmd_d = Cmd9; arg_d = '0; crc_d = 8'h01; pre_d = 1'b0;
                  end
                end
                Cmd9: begin
                  cnt_d = cnt_q;
                  if (rx_byte_i != 8'd0) begin
                    kind_d = KindError; phase_d = PhIdle; done = 1'b1;
                    lst_d = StInitFail; txv = 1'b0;
                  end else phase_d = PhCsdtok;
                end
                Cmd17, Cmd18: begin
                  if (rx_byte_i != 8'd0) begin
                    phase_d = PhIdle; done = 1'b1; lst_d = StReject; txv = 1'b0;
                    cnt_d = cnt_q;
                  end else if (cmd_q == Cmd18 && left_q == 8'd0) begin
                    cmd_d = Cmd12; arg_d = '0; crc_d = 8'h01; pre_d = 1'b0;
                  end else begin
                    phase_d = PhDtok; cnt_d = cnt_q;
                  end
                end
                default: begin
                  phase_d = PhIdle; done = 1'b1; txv = 1'b0; cnt_d = cnt_q;
                  lst_d = (rx_byte_i == 8'd0) ? StOk : StReject;
                end
              endcase
            end
          end
        end
        PhEcho: begin
          if (rx_byte_i != echo_exp) begin
            kind_d = KindError; phase_d = PhIdle; done = 1'b1;
            lst_d = StInitFail; txv = 1'b0;
          end else begin
            cnt_d = cnt_inc;
            if (cnt_inc >= 10'd4) begin
              kind_d = KindHigh; cmd_d = Cmd41; arg_d = 32'h4000_0000;
              crc_d = 8'h01; pre_d = 1'b1; phase_d = PhCpre; cnt_d = '0;
            end
          end
        end
        PhCsdtok: if (rx_byte_i != 8'hFF) begin
          phase_d = PhCsd; cnt_d = '0;
        end
        PhCsd: begin
          if (cnt_q == 10'd0) begin
            kind_d = rx_byte_i[6] ? KindHigh : KindStd;
            size_d = '0; mult_d = '0; bl_d = '0;
          end else if (kind_q == KindHigh) begin
            if (cnt_q == 10'd7) size_d = {rx_byte_i[5:0], 16'd0};
            else if (cnt_q == 10'd8) size_d = {size_q[21:16], rx_byte_i, size_q[7:0]};
            else if (cnt_q == 10'd9) size_d = {size_q[21:8], rx_byte_i};
          end else begin
            if (cnt_q == 10'd5) bl_d = rx_byte_i[3:0];
            else if (cnt_q == 10'd6) size_d = {10'd0, rx_byte_i[1:0], 10'd0};
            else if (cnt_q == 10'd7) size_d = {size_q[21:10], rx_byte_i, size_q[1:0]};
            else if (cnt_q == 10'd8) size_d = {size_q[21:2], rx_byte_i[7:6]};
            else if (cnt_q == 10'd9) mult_d = {rx_byte_i[1:0], 1'b0};
            else if (cnt_q == 10'd10) mult_d = {mult_q[2:1], rx_byte_i[7]};
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= 10'd16) begin
            // capacity from the decoded fields, all set before the last byte
            cap_d = (kind_q == KindHigh) ? ({11'd0, size_q} + 33'd1) << 10 : cap_std;
            phase_d = PhIdle; done = 1'b1; lst_d = StOk; txv = 1'b0;
          end
        end
        PhDtok: if (rx_byte_i == 8'hFE) begin
          phase_d = PhData; cnt_d = '0;
        end
        PhData: begin
          dv = 1'b1; dat = rx_byte_i; cnt_d = cnt_inc;
          if (cnt_inc == 10'd512) begin
            bend = 1'b1; phase_d = PhDcrc; cnt_d = '0;
          end
        end
        PhDcrc: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= 10'd2) begin
            if (cmd_q == Cmd17) begin
              phase_d = PhIdle; done = 1'b1; lst_d = StOk; txv = 1'b0;
            end else begin
              left_d = left_q - 8'd1;
              if (left_q == 8'd1) begin
                cmd_d = Cmd12; arg_d = '0; crc_d = 8'h01; pre_d = 1'b0;
                phase_d = PhCpre; cnt_d = '0;
              end else phase_d = PhDtok;
            end
          end
        end
        default: begin
          phase_d = PhIdle; txv = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; cnt_q <= '0; arg_q <= '0; left_q <= '0;
      kind_q <= KindUnknown; bl_q <= '0; size_q <= '0; mult_q <= '0;
      cap_q <= '0; resp_q <= 8'hFF; sel_q <= 1'b0; lst_q <= StOk;
      cmd_q <= Cmd0; crc_q <= '0; pre_q <= 1'b0;
      res_o <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; cnt_q <= cnt_d; arg_q <= arg_d; left_q <= left_d;
      kind_q <= kind_d; bl_q <= bl_d; size_q <= size_d; mult_q <= mult_d;
      cap_q <= cap_d; resp_q <= resp_d; sel_q <= sel_d; lst_q <= lst_d;
      cmd_q <= cmd_d; crc_q <= crc_d; pre_q <= pre_d;
      res_o.tx_valid        <= txv;
      res_o.tx_byte         <= tx;
      res_o.select_active   <= sel_d;
      res_o.data_valid      <= dv;
      res_o.data_byte       <= dat;
      res_o.block_end       <= bend;
      res_o.done_res        <= done;
      res_o.status          <= (phase_d != PhIdle) ? StBusy : lst_d;
      res_o.r1_response     <= resp_d;
      res_o.card_kind       <= kind_d;
      res_o.capacity_blocks <= cap_d;
    end
  end

endmodule

// ===== rtl/sd_spi_host_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer: sd card host sequencer in spi mode
// one spi byte exchange per request; init, single and multi block reads
// ----------------------------------------------------------------------------
// a result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle, held back only while a result waits
// the result register is loaded on each accepted request, while it is empty or being taken
// reset (async, active low) returns the sequencer to idle, no card known,
// last response 0xff and no result pending
module sd_spi_host_sequencer #(
  parameter int unsigned InitIdleBytes = sdspi_pkg::InitIdleBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] block_addr_i,
  input  logic [7:0]  block_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        select_active_o,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        block_end_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [7:0]  r1_response_o,
  output logic [1:0]  card_kind_o,
  output logic [32:0] capacity_blocks_o
);
  import sdspi_pkg::*;

  result_t res;
  logic    valid_q;
  logic    take;

  // request taken whenever the result slot is free or drains this cycle
  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  sdspi_core #(.InitIdleBytes(InitIdleBytes)) u_core (
    .clk_i, .rst_ni,
    .step_i       (take),
    .opcode_i, .rx_byte_i, .block_addr_i, .block_count_i,
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (in_ready_o) valid_q <= in_valid_i;
  end

  assign out_valid_o       = valid_q;
  assign tx_valid_o        = res.tx_valid;
  assign tx_byte_o         = res.tx_byte;
  assign select_active_o   = res.select_active;
  assign data_valid_o      = res.data_valid;
  assign data_byte_o       = res.data_byte;
  assign block_end_o       = res.block_end;
  assign done_res_o        = res.done_res;
  assign status_o          = res.status;
  assign r1_response_o     = res.r1_response;
  assign card_kind_o       = res.card_kind;
  assign capacity_blocks_o = res.capacity_blocks;

endmodule

// ===== dv/sd_spi_host_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer_checker: scoreboard of the sd spi host sequencer
// watches both channels, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sd_spi_host_sequencer_checker #(
  parameter int unsigned InitIdleBytes = sdspi_pkg::InitIdleBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [31:0]        block_addr_i,
  input  logic [7:0]         block_count_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  sdspi_pkg::result_t actual_i,
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o
);
  import sdspi_pkg::*;

  localparam int unsigned BlockBytes = 512;

  // mirrored sequencer state
  logic [3:0]  seq_phase;
  logic [9:0]  seq_count;
  logic [31:0] seq_arg;
  logic [7:0]  seq_left;
  logic [1:0]  seq_kind;
  logic [3:0]  seq_bl_len;
  logic [21:0] seq_csize;
  logic [2:0]  seq_cmult;
  logic [32:0] seq_cap;
  logic [7:0]  seq_resp;
  logic        seq_sel;
  logic [1:0]  seq_status;
  logic [5:0]  seq_cmd;
  logic [7:0]  seq_crc;
  logic        seq_prefix;
  result_t     step_res;

  result_t expected_results[$];

  assign outstanding_o = expected_results.size();

  function automatic void drive_byte(logic [7:0] b);
    step_res.tx_valid = 1'b1;
    step_res.tx_byte  = b;
  endfunction

  function automatic void end_operation(logic [1:0] st);
    seq_phase         = PhIdle;
    step_res.done_res = 1'b1;
    seq_status        = st;
    step_res.tx_valid = 1'b0;
    step_res.tx_byte  = 8'hFF;
  endfunction

  function automatic void launch_command(logic [5:0] code, logic [31:0] arg,
                                         logic [7:0] crc, logic acmd);
    seq_cmd    = code;
    seq_arg    = arg;
    seq_crc    = crc;
    seq_prefix = acmd;
    seq_phase  = PhCpre;
    seq_count  = '0;
    drive_byte(8'hFF);
  endfunction

  function automatic logic [7:0] command_frame_byte(int unsigned k);
    if (seq_prefix) begin
      if (k == 0) return 8'h40 + 8'd55;
      return (k == 5) ? 8'h01 : 8'h00;
    end
    if (k == 0) return {2'b01, seq_cmd};
    if (k == 5) return seq_crc;
    return seq_arg[8*(4-k) +: 8];
  endfunction

  function automatic void decode_capacity();
    logic [3:0]  len;
    logic [63:0] c;
    if (seq_kind == KindHigh) begin
      seq_cap = ({11'd0, seq_csize} + 33'd1) << 10;
    end else begin
      len = (seq_bl_len < 4'd9) ? 4'd9 : seq_bl_len;
      c = ({52'd0, seq_csize[11:0]} + 64'd1) << ({1'b0, seq_cmult} + 4'd2);
      c = c << (len - 4'd9);
      seq_cap = c[32:0];
    end
  endfunction

  function automatic void handle_response(logic [7:0] r);
    case (seq_cmd)
      Cmd0: launch_command(Cmd8, 32'h0000_01AA, 8'h87, 1'b0);
      Cmd8: begin
        if (r == 8'd5) begin
          seq_kind = KindStd;
          launch_command(Cmd41, 32'h4000_0000, 8'h01, 1'b1);
        end else if (r == 8'd1) begin
          seq_phase = PhEcho;
          seq_count = '0;
          drive_byte(8'hFF);
        end else begin
          seq_kind = KindError;
          end_operation(StInitFail);
        end
      end
      Cmd41: begin
        if (r == 8'd1) launch_command(Cmd41, 32'h4000_0000, 8'h01, 1'b1);
        else launch_command(Cmd9, 32'd0, 8'h01, 1'b0);
      end
      Cmd9: begin
        if (r != 8'd0) begin
          seq_kind = KindError;
          end_operation(StInitFail);
        end else begin
          seq_phase = PhCsdtok;
          drive_byte(8'hFF);
        end
      end
      Cmd17, Cmd18: begin
        if (r != 8'd0) end_operation(StReject);
        else if (seq_cmd == Cmd18 && seq_left == 8'd0)
          launch_command(Cmd12, 32'd0, 8'h01, 1'b0);
        else begin
          seq_phase = PhDtok;
          drive_byte(8'hFF);
        end
      end
      default: end_operation((r == 8'd0) ? StOk : StReject);
    endcase
  endfunction

  function automatic void take_csd_byte(logic [7:0] rx);
    int unsigned k;
    k = seq_count;
    if (k == 0) begin
      seq_kind   = rx[6] ? KindHigh : KindStd;
      seq_csize  = '0;
      seq_cmult  = '0;
      seq_bl_len = '0;
    end else if (seq_kind == KindHigh) begin
      if (k == 7) seq_csize = {rx[5:0], 16'd0};
      else if (k == 8) seq_csize[15:8] = rx;
      else if (k == 9) seq_csize[7:0] = rx;
    end else begin
      if (k == 5) seq_bl_len = rx[3:0];
      else if (k == 6) seq_csize = {10'd0, rx[1:0], 10'd0};
      else if (k == 7) seq_csize[9:2] = rx;
      else if (k == 8) seq_csize[1:0] = rx[7:6];
      else if (k == 9) seq_cmult = {rx[1:0], 1'b0};
      else if (k == 10) seq_cmult[0] = rx[7];
    end
    seq_count++;
    if (seq_count >= 16) begin
      decode_capacity();
      end_operation(StOk);
    end else drive_byte(8'hFF);
  endfunction

  // one spi exchange of an active sequence
  function automatic void take_card_byte(logic [7:0] rx);
    logic [7:0] echo_b;
    case (seq_phase)
      PhClocks: begin
        seq_count++;
        if (seq_count < InitIdleBytes) drive_byte(8'hFF);
        else begin
          seq_sel = 1'b1;
          launch_command(Cmd0, 32'd0, 8'h95, 1'b0);
        end
      end
      PhCpre: begin
        seq_phase = PhCbyte;
        seq_count = '0;
        drive_byte(command_frame_byte(0));
      end
      PhCbyte: begin
        seq_count++;
        if (seq_count < 6) drive_byte(command_frame_byte(seq_count));
        else begin
          seq_phase = (!seq_prefix && seq_cmd == Cmd12) ? PhCskip : PhCpoll;
          drive_byte(8'hFF);
        end
      end
      PhCskip: begin
        seq_phase = PhCpoll;
        drive_byte(8'hFF);
      end
      PhCpoll: begin
        if (rx == 8'hFF) drive_byte(8'hFF);
        else begin
          seq_resp = rx;
          if (seq_prefix) begin
            seq_prefix = 1'b0;
            seq_phase  = PhCpre;
            drive_byte(8'hFF);
          end else handle_response(rx);
        end
      end
      PhEcho: begin
        case (seq_count[1:0])
          2'd2:    echo_b = 8'h01;
          2'd3:    echo_b = 8'hAA;
          default: echo_b = 8'h00;
        endcase
        if (rx != echo_b) begin
          seq_kind = KindError;
          end_operation(StInitFail);
        end else begin
          seq_count++;
          if (seq_count >= 4) begin
            seq_kind = KindHigh;
            launch_command(Cmd41, 32'h4000_0000, 8'h01, 1'b1);
          end else drive_byte(8'hFF);
        end
      end
      PhCsdtok: begin
        if (rx != 8'hFF) begin
          seq_phase = PhCsd;
          seq_count = '0;
        end
        drive_byte(8'hFF);
      end
      PhCsd: take_csd_byte(rx);
      PhDtok: begin
        if (rx == 8'hFE) begin
          seq_phase = PhData;
          seq_count = '0;
        end
        drive_byte(8'hFF);
      end
      PhData: begin
        step_res.data_valid = 1'b1;
        step_res.data_byte  = rx;
        seq_count++;
        if (seq_count >= BlockBytes) begin
          step_res.block_end = 1'b1;
          seq_phase = PhDcrc;
          seq_count = '0;
        end
        drive_byte(8'hFF);
      end
      PhDcrc: begin
        seq_count++;
        if (seq_count < 2) drive_byte(8'hFF);
        else if (seq_cmd == Cmd17) end_operation(StOk);
        else begin
          seq_left--;
          if (seq_left == 8'd0) launch_command(Cmd12, 32'd0, 8'h01, 1'b0);
          else begin
            seq_phase = PhDtok;
            drive_byte(8'hFF);
          end
        end
      end
      default: seq_phase = PhIdle;
    endcase
  endfunction

  function automatic result_t predict_exchange(logic [1:0] op, logic [7:0] rx,
                                               logic [31:0] addr, logic [7:0] cnt);
    step_res = '0;
    step_res.tx_byte = 8'hFF;
    if (seq_phase == PhIdle) begin
      if (op == OpInit) begin
        seq_sel   = 1'b0;
        seq_phase = PhClocks;
        seq_count = '0;
        drive_byte(8'hFF);
      end else if (op == OpRead1 || op == OpReadN) begin
        seq_sel  = 1'b1;
        seq_left = cnt;
        launch_command((op == OpRead1) ? Cmd17 : Cmd18,
                       (seq_kind == KindStd) ? (addr << 9) : addr, 8'h01, 1'b0);
      end
    end else if (op == OpByte) begin
      take_card_byte(rx);
    end
    step_res.select_active   = seq_sel;
    step_res.status          = (seq_phase != PhIdle) ? StBusy : seq_status;
    step_res.r1_response     = seq_resp;
    step_res.card_kind       = seq_kind;
    step_res.capacity_blocks = seq_cap;
    return step_res;
  endfunction

  task automatic compare_field(string name, logic [32:0] exp_v, logic [32:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      seq_phase  = PhIdle;
      seq_count  = '0;
      seq_arg    = '0;
      seq_left   = '0;
      seq_kind   = KindUnknown;
      seq_bl_len = '0;
      seq_csize  = '0;
      seq_cmult  = '0;
      seq_cap    = '0;
      seq_resp   = 8'hFF;
      seq_sel    = 1'b0;
      seq_status = StOk;
      seq_cmd    = Cmd0;
      seq_crc    = '0;
      seq_prefix = 1'b0;
      mismatches_o = 0;
      expected_results.delete();
    end else begin
      // results first: a result always belongs to an earlier request
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatches_o++;
        end else begin
          exp_r = expected_results.pop_front();
          compare_field("tx_valid", exp_r.tx_valid, actual_i.tx_valid);
          compare_field("tx_byte", exp_r.tx_byte, actual_i.tx_byte);
          compare_field("select_active", exp_r.select_active, actual_i.select_active);
          compare_field("data_valid", exp_r.data_valid, actual_i.data_valid);
          compare_field("data_byte", exp_r.data_byte, actual_i.data_byte);
          compare_field("block_end", exp_r.block_end, actual_i.block_end);
          compare_field("done_res", exp_r.done_res, actual_i.done_res);
          compare_field("status", exp_r.status, actual_i.status);
          compare_field("r1_response", exp_r.r1_response, actual_i.r1_response);
          compare_field("card_kind", exp_r.card_kind, actual_i.card_kind);
          compare_field("capacity_blocks", exp_r.capacity_blocks,
                        actual_i.capacity_blocks);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(
          predict_exchange(opcode_i, rx_byte_i, block_addr_i, block_count_i));
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sd spi host sequencer
// scripted card conversations (init variants, single and multi block reads)
// with random content, gaps and stalls; checking lives in the checker module
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import sdspi_pkg::*;

  localparam int unsigned RandomRequests = 1750;
  localparam int unsigned CycleLimit     = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = OpByte;
  logic [7:0]  rx_byte_i = 8'hFF;
  logic [31:0] block_addr_i = '0;
  logic [7:0]  block_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  result_t     dut_result;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned burst_left = 0;
  bit          card_busy = 1'b0;

  always #1 clk_i = ~clk_i;

  sd_spi_host_sequencer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .rx_byte_i        (rx_byte_i),
    .block_addr_i     (block_addr_i),
    .block_count_i    (block_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tx_valid_o       (dut_result.tx_valid),
    .tx_byte_o        (dut_result.tx_byte),
    .select_active_o  (dut_result.select_active),
    .data_valid_o     (dut_result.data_valid),
    .data_byte_o      (dut_result.data_byte),
    .block_end_o      (dut_result.block_end),
    .done_res_o       (dut_result.done_res),
    .status_o         (dut_result.status),
    .r1_response_o    (dut_result.r1_response),
    .card_kind_o      (dut_result.card_kind),
    .capacity_blocks_o(dut_result.capacity_blocks)
  );

  sd_spi_host_sequencer_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .opcode_i     (opcode_i),
    .rx_byte_i    (rx_byte_i),
    .block_addr_i (block_addr_i),
    .block_count_i(block_count_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .actual_i     (dut_result),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver: windows of free flow alternate with windows of random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (cycle_count[6]) out_ready_i <= ($urandom_range(0, 3) != 0);
    else if (cycle_count[5]) out_ready_i <= ($urandom_range(0, 1) != 0);
    else out_ready_i <= 1'b1;
  end

  // one request, sent in bursts with random gaps between them
  task automatic push_request(logic [1:0] op, logic [7:0] rx, logic [31:0] addr,
                              logic [7:0] cnt);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    rx_byte_i     <= rx;
    block_addr_i  <= addr;
    block_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
  endtask

  // a card byte; now and then a start request that a busy sequencer ignores
  task automatic push_byte(logic [7:0] rx);
    if (card_busy && $urandom_range(0, 24) == 0)
      push_request(2'($urandom_range(1, 3)), 8'($urandom), $urandom, 8'($urandom));
    push_request(OpByte, rx, $urandom, 8'($urandom));
  endtask

  task automatic push_random_bytes(int unsigned n);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_non_ff();
    return 8'($urandom_range(0, 254));
  endfunction

  // command frame, optional stuff byte, some busy polls, then the r1 answer
  task automatic exchange_command(logic [7:0] r1, bit stuff_byte);
    push_random_bytes(7 + stuff_byte);
    repeat ($urandom_range(0, 3)) push_byte(8'hFF);
    push_byte(r1);
  endtask

  // full init conversation; mode picks which branch the card takes
  task automatic run_init(int unsigned mode);
    logic [7:0] r;
    logic [7:0] echo_b;
    int unsigned bad_pos;
    bit broken;
    card_busy = 1'b1;
    push_request(OpInit, 8'($urandom), $urandom, 8'($urandom));
    push_random_bytes(InitIdleBytesDef);
    exchange_command(pick_non_ff(), 1'b0);
    if (mode == 0) begin
      // cmd8 answer neither 1 nor 5: init fails
      do r = pick_non_ff(); while (r == 8'd1 || r == 8'd5);
      exchange_command(r, 1'b0);
      card_busy = 1'b0;
      return;
    end else if (mode == 1) begin
      exchange_command(8'd5, 1'b0);
    end else begin
      exchange_command(8'd1, 1'b0);
      broken  = (mode == 2);
      bad_pos = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
        echo_b = (i == 2) ? 8'h01 : (i == 3) ? 8'hAA : 8'h00;
        if (broken && i == bad_pos) echo_b ^= 8'h01 << $urandom_range(0, 7);
        push_byte(echo_b);
        if (broken && i == bad_pos) begin
          card_busy = 1'b0;
          return;
        end
      end
    end
    // acmd41 loop while the card stays idle
    repeat ($urandom_range(0, 3)) begin
      exchange_command(pick_non_ff(), 1'b0);
      exchange_command(8'd1, 1'b0);
    end
    exchange_command(pick_non_ff(), 1'b0);
    do r = pick_non_ff(); while (r == 8'd1);
    exchange_command(r, 1'b0);
    // cmd9, occasionally rejected
    r = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 254)) : 8'd0;
    exchange_command(r, 1'b0);
    if (r == 8'd0) begin
      repeat ($urandom_range(0, 3)) push_byte(8'hFF);
      push_byte(pick_non_ff());
      push_random_bytes(16);
    end
    card_busy = 1'b0;
  endtask

  // read conversation; reject forces a nonzero answer to the read command
  task automatic run_read(logic [1:0] op, logic [31:0] addr, logic [7:0] cnt,
                          bit reject);
    logic [7:0] r;
    int unsigned blocks;
    card_busy = 1'b1;
    push_request(op, 8'($urandom), addr, cnt);
    r = reject ? 8'($urandom_range(1, 254)) : 8'd0;
    exchange_command(r, 1'b0);
    if (reject) begin
      card_busy = 1'b0;
      return;
    end
    blocks = (op == OpRead1) ? 1 : cnt;
    repeat (blocks) begin
      // tokens other than the start token are waited out
      repeat ($urandom_range(0, 3)) begin
        do r = 8'($urandom_range(0, 255)); while (r == 8'hFE);
        push_byte(r);
      end
      push_byte(8'hFE);
      push_random_bytes(512 + 2);
    end
    if (op == OpReadN) begin
      r = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 254)) : 8'd0;
      exchange_command(r, 1'b1);
    end
    card_busy = 1'b0;
  endtask

  initial begin
    int unsigned pick;
    logic [31:0] addr;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stray byte while idle, read with no card known
    push_request(OpByte, 8'h00, 32'hFFFF_FFFF, 8'hFF);
    run_read(OpRead1, 32'hFFFF_FFFF, 8'd0, 1'b1);
    run_read(OpReadN, 32'h0000_0000, 8'hFF, 1'b1);
    run_read(OpReadN, 32'h8000_0001, 8'd0, 1'b0);
    // every init branch, then reads against the resulting card kinds
    run_init(0);
    run_init(2);
    run_read(OpRead1, 32'hFFFF_FFFF, 8'd0, 1'b1);
    run_init(1);
    run_read(OpReadN, 32'h007F_FFFF, 8'd0, 1'b0);
    run_read(OpRead1, 32'hFFFF_FFFF, 8'd1, 1'b0);
    run_init(3);
    run_read(OpReadN, 32'h0000_0001, 8'd2, 1'b0);

    // random conversations, mostly well formed
    while (requests_sent < RandomRequests) begin
      pick = $urandom_range(0, 15);
      addr = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0)
                                        : $urandom;
      if (pick < 6) run_init($urandom_range(0, 5));
      else if (pick < 11) run_read(2'($urandom_range(2, 3)), addr, 8'($urandom), 1'b1);
      else if (pick < 13) run_read(OpReadN, addr, 8'd0, 1'b0);
      else if (pick < 15) run_read(2'($urandom_range(2, 3)), addr,
                                   8'($urandom_range(1, 2)), 1'b0);
      else push_random_bytes($urandom_range(1, 4));
    end

    in_valid_i <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
